// ----- hdl/sdspi_pkg.sv -----
// ----------------------------------------------------------------------------
// SD SPI command unit package
// Shared item types, status codes, frame constants and the CRC7 byte update.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int POLL_W      = 17;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 17'h10000;

  // Input item kinds.
  localparam logic OP_START = 1'b0;
  localparam logic OP_XFER  = 1'b1;

  // Completion status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_CMD = 3'd1;
  localparam logic [2:0] ST_COM_ERR = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_R1_ERR  = 3'd4;

  // Command frame constants.
  localparam logic [7:0] CMD_LIMIT   = 8'd64;
  localparam logic [7:0] START_TOKEN = 8'h40;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] R1_ERR_MASK = 8'h7C;
  localparam logic [7:0] CRC7_GEN    = 8'h89;
  localparam logic [2:0] FRAME_LAST  = 3'd4;
  localparam logic [2:0] FRAME_BYTES = 3'd5;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  cmd_index;
    logic [31:0] argument;
    logic [3:0]  resp_len;
    logic [7:0]  rx_byte;
    logic        bus_error;
  } sdspi_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       resp_valid;
    logic [7:0] resp_byte;
    logic       done_res;
    logic [2:0] status;
  } sdspi_res_t;

  // Folds one frame byte into the running CRC7, most significant bit first.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = {crc, 1'b0} ^ data;
    if (v[7]) begin
      v = v ^ CRC7_GEN;
    end
    for (int i = 1; i < 8; i++) begin
      v = {v[6:0], 1'b0};
      if (v[7]) begin
        v = v ^ CRC7_GEN;
      end
    end
    return v[6:0];
  endfunction

endpackage

// ----- hdl/sd_spi_command_transaction_unit.sv -----
// ----------------------------------------------------------------------------
// SD SPI command transaction unit
// Runs one SPI-mode SD command exchange, one bus byte per input item.
// ----------------------------------------------------------------------------
// Usage: the controller sends a start item (in_tuser = 0) with the command
// index, argument and expected response length. Each reply item names the
// next byte to clock out on the bus. After every completed SPI byte the
// controller sends an exchange item (in_tuser = 1) with the received byte and
// the bus error flag. The block answers each exchange with the next byte to
// send, a captured response byte, or a completion with its status. A start
// while busy and an exchange while idle are dropped without a reply.
// An accepted item passes through the input register, the next-byte logic
// with the CRC7 update and the output register before it reaches out_tvalid.
// Throughput is one item per cycle while out_tready is high; the CRC is folded
// in one byte per frame byte so the logic stays a single byte deep.
// When out_tready is low the output register holds its item, the input
// register fills, and in_tready drops until the output is taken.
// Reset (synchronous, rst_n low) empties both registers, returns the
// sequencer to idle and sets the poll limit to 65536. cfg_wr_en writes the
// poll limit in the same cycle; write it only while no transaction runs.
// ----------------------------------------------------------------------------
module sd_spi_command_transaction_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input item.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // cmd_index[7:0], argument[39:8], resp_len[43:40], rx_byte[51:44],
  // bus_error[52], zero fill above.
  input  logic [sdspi_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode: 0 start, 1 byte exchange completed.
  input  logic                                 in_tuser,
  // Result item.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // send_valid[0], send_byte[8:1], resp_valid[9], resp_byte[17:10],
  // done_res[18], status[21:19], zero fill above.
  output logic [sdspi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Poll limit register.
  input  logic                                 cfg_wr_en,
  input  logic [sdspi_pkg::POLL_W-1:0]         cfg_wr_data
);

  logic                         s1_valid_r, s1_valid_nxt;
  sdspi_pkg::sdspi_item_t       s1_item_r;
  logic                         out_valid_r, out_valid_nxt;
  sdspi_pkg::sdspi_res_t        out_res_r;
  logic [sdspi_pkg::POLL_W-1:0] poll_limit_r;

  logic                         slot_free;
  logic                         advance;
  logic                         in_accept;
  sdspi_pkg::sdspi_res_t        core_res;
  logic                         core_present;

  // The output slot frees when it is empty or being taken this cycle.
  assign slot_free = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && slot_free;
  assign in_tready = !s1_valid_r || slot_free;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = slot_free ? (s1_valid_r && core_present) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      poll_limit_r <= sdspi_pkg::POLL_LIMIT_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        poll_limit_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.opcode    <= in_tuser;
      s1_item_r.cmd_index <= in_tdata[7:0];
      s1_item_r.argument  <= in_tdata[39:8];
      s1_item_r.resp_len  <= in_tdata[43:40];
      s1_item_r.rx_byte   <= in_tdata[51:44];
      s1_item_r.bus_error <= in_tdata[52];
    end
    if (advance && core_present) begin
      out_res_r <= core_res;
    end
  end

  sdspi_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .item        (s1_item_r),
    .poll_limit  (poll_limit_r),
    .res         (core_res),
    .res_present (core_present)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_res_r.status,
                       out_res_r.done_res,
                       out_res_r.resp_byte,
                       out_res_r.resp_valid,
                       out_res_r.send_byte,
                       out_res_r.send_valid};

`ifndef ASSERT_OFF
  // A staged item that cannot move on must block new input.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !slot_free |=> s1_valid_r && $stable(s1_item_r))
    else $error("sd_spi_command_transaction_unit: staged item lost");
`endif

endmodule

// ----- hdl/sdspi_core.sv -----
// ----------------------------------------------------------------------------
// SD SPI command sequencer
// Holds the transaction state and decides the next bus byte for each item.
// ----------------------------------------------------------------------------
module sdspi_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  sdspi_pkg::sdspi_item_t          item,
  input  logic [sdspi_pkg::POLL_W-1:0]    poll_limit,
  output sdspi_pkg::sdspi_res_t           res,
  output logic                            res_present
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_POLL  = 3'd2;
  localparam logic [2:0] PH_RESP  = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;

  logic [2:0]                   phase_r, phase_nxt;
  logic [2:0]                   byte_idx_r, byte_idx_nxt;
  logic [31:0]                  arg_r, arg_nxt;
  logic [6:0]                   crc_r, crc_nxt;
  logic [sdspi_pkg::POLL_W-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [3:0]                   resp_tgt_r, resp_tgt_nxt;
  logic [3:0]                   resp_cnt_r, resp_cnt_nxt;
  logic [2:0]                   final_st_r, final_st_nxt;
  logic [7:0]                   first_byte;

  assign first_byte = sdspi_pkg::START_TOKEN | item.cmd_index;

  always_comb begin
    phase_nxt    = phase_r;
    byte_idx_nxt = byte_idx_r;
    arg_nxt      = arg_r;
    crc_nxt      = crc_r;
    poll_cnt_nxt = poll_cnt_r;
    resp_tgt_nxt = resp_tgt_r;
    resp_cnt_nxt = resp_cnt_r;
    final_st_nxt = final_st_r;
    res          = '0;
    res_present  = 1'b0;

    if (item.opcode == sdspi_pkg::OP_START) begin
      if (phase_r == PH_IDLE) begin
        res_present = 1'b1;
        if (item.cmd_index >= sdspi_pkg::CMD_LIMIT) begin
          res.done_res = 1'b1;
          res.status   = sdspi_pkg::ST_BAD_CMD;
        end else begin
          arg_nxt      = item.argument;
          crc_nxt      = sdspi_pkg::crc7_byte(7'd0, first_byte);
          resp_tgt_nxt = (item.resp_len == 4'd0) ? 4'd1 : item.resp_len;
          resp_cnt_nxt = 4'd0;
          poll_cnt_nxt = '0;
          byte_idx_nxt = 3'd0;
          final_st_nxt = sdspi_pkg::ST_OK;
          phase_nxt    = PH_CMD;
          res.send_valid = 1'b1;
          res.send_byte  = first_byte;
        end
      end
    end else begin
      case (phase_r)
        PH_CMD: begin
          res_present = 1'b1;
          if (item.bus_error) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = sdspi_pkg::ST_COM_ERR;
          end else if (byte_idx_r >= sdspi_pkg::FRAME_BYTES) begin
            phase_nxt      = PH_POLL;
            poll_cnt_nxt   = '0;
            res.send_valid = 1'b1;
            res.send_byte  = sdspi_pkg::FILL_BYTE;
          end else begin
            byte_idx_nxt   = byte_idx_r + 3'd1;
            res.send_valid = 1'b1;
            if (byte_idx_r < sdspi_pkg::FRAME_LAST) begin
              // Argument bytes go out most significant first; the CRC follows them.
              res.send_byte = arg_r[31:24];
              arg_nxt       = {arg_r[23:0], 8'd0};
              crc_nxt       = sdspi_pkg::crc7_byte(crc_r, arg_r[31:24]);
            end else begin
              res.send_byte = {crc_r, 1'b1};
            end
          end
        end
        PH_POLL: begin
          res_present = 1'b1;
          if (item.bus_error) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = sdspi_pkg::ST_COM_ERR;
          end else begin
            poll_cnt_nxt = poll_cnt_r + 1'b1;
            if (!item.rx_byte[7]) begin
              resp_cnt_nxt = 4'd1;
              if ((item.rx_byte & sdspi_pkg::R1_ERR_MASK) != 8'd0) begin
                final_st_nxt = sdspi_pkg::ST_R1_ERR;
                phase_nxt    = PH_TRAIL;
              end else if (resp_tgt_r > 4'd1) begin
                phase_nxt = PH_RESP;
              end else begin
                final_st_nxt = sdspi_pkg::ST_OK;
                phase_nxt    = PH_TRAIL;
              end
              res.send_valid = 1'b1;
              res.send_byte  = sdspi_pkg::FILL_BYTE;
              res.resp_valid = 1'b1;
              res.resp_byte  = item.rx_byte;
            end else if (poll_cnt_nxt >= poll_limit) begin
              phase_nxt    = PH_IDLE;
              res.done_res = 1'b1;
              res.status   = sdspi_pkg::ST_TIMEOUT;
            end else begin
              res.send_valid = 1'b1;
              res.send_byte  = sdspi_pkg::FILL_BYTE;
            end
          end
        end
        PH_RESP: begin
          res_present = 1'b1;
          if (item.bus_error) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = sdspi_pkg::ST_COM_ERR;
          end else begin
            resp_cnt_nxt = resp_cnt_r + 4'd1;
            if (resp_cnt_nxt >= resp_tgt_r) begin
              final_st_nxt = sdspi_pkg::ST_OK;
              phase_nxt    = PH_TRAIL;
            end
            res.send_valid = 1'b1;
            res.send_byte  = sdspi_pkg::FILL_BYTE;
            res.resp_valid = 1'b1;
            res.resp_byte  = item.rx_byte;
          end
        end
        PH_TRAIL: begin
          // A bus error on the trailing byte does not change the outcome.
          res_present  = 1'b1;
          phase_nxt    = PH_IDLE;
          res.done_res = 1'b1;
          res.status   = final_st_r;
        end
        default: begin
          res_present = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      byte_idx_r <= 3'd0;
      arg_r      <= 32'd0;
      crc_r      <= 7'd0;
      poll_cnt_r <= '0;
      resp_tgt_r <= 4'd0;
      resp_cnt_r <= 4'd0;
      final_st_r <= sdspi_pkg::ST_OK;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      byte_idx_r <= byte_idx_nxt;
      arg_r      <= arg_nxt;
      crc_r      <= crc_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      resp_tgt_r <= resp_tgt_nxt;
      resp_cnt_r <= resp_cnt_nxt;
      final_st_r <= final_st_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Every completion returns the sequencer to idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_present && res.done_res |=> phase_r == PH_IDLE)
    else $error("sdspi_core: transaction ended but sequencer is not idle");

  // While trailing response bytes are collected, the count stays below the target.
  a_resp_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RESP |-> (resp_cnt_r < resp_tgt_r) && (resp_cnt_r != 4'd0))
    else $error("sdspi_core: response count out of range");

  // A returned response byte never comes with a completion.
  a_resp_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_present && res.resp_valid |-> !res.done_res && res.send_valid)
    else $error("sdspi_core: response byte paired with completion");
`endif

endmodule

// ----- verif/sd_spi_command_transaction_unit_test.sv -----
// ----------------------------------------------------------------------------
// SD SPI command transaction unit testbench
// Drives command starts and completed byte exchanges into the unit, predicts
// every reply with a cycle-free model of the exchange sequencer (frame bytes,
// CRC7, polling, response capture, trailing byte) and compares each reply
// field by field. A short directed table comes first, then random but mostly
// well-formed transactions across several poll limit settings.
// ----------------------------------------------------------------------------
module sd_spi_command_transaction_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 7;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 6;
  localparam int CYCLE_LIMIT  = 200000;
  // Two register stages inside the unit; the settle wait also covers a dropped
  // item that may still sit in the input register.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;

  // Sequencer phases of the prediction.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FRAME,
    SEQ_POLL,
    SEQ_DATA,
    SEQ_TRAIL
  } seq_phase_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: either an item (with an optional reply
  // typed in by hand) or a poll limit write.
  typedef struct {
    row_kind_t                    kind;
    sdspi_pkg::sdspi_item_t       item;
    logic [sdspi_pkg::POLL_W-1:0] limit;
    bit                           typed;
    sdspi_pkg::sdspi_res_t        reply;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [sdspi_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                              in_tuser = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [sdspi_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              cfg_wr_en = 1'b0;
  logic [sdspi_pkg::POLL_W-1:0]      cfg_wr_data = '0;

  // Predicted state of the exchange sequencer.
  seq_phase_t                   seq_phase = SEQ_IDLE;
  logic [2:0]                   frame_pos = '0;
  logic [31:0]                  arg_latch = '0;
  logic [6:0]                   frame_crc = '0;
  logic [sdspi_pkg::POLL_W-1:0] polls_made = '0;
  logic [3:0]                   resp_goal = '0;
  logic [3:0]                   resp_seen = '0;
  logic [2:0]                   end_status = sdspi_pkg::ST_OK;
  logic [sdspi_pkg::POLL_W-1:0] poll_limit_now = sdspi_pkg::POLL_LIMIT_RST;

  sdspi_pkg::sdspi_res_t pending_replies[$];
  stim_row_t             stim_table[$];
  int unsigned           mismatches = 0;
  int unsigned           cycle_count = 0;
  int unsigned           polls_to_wait = 0;
  bit                    quiet = 1'b0;

  sd_spi_command_transaction_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC7 of the five-byte command frame, shifted in one bit at a time,
  // most significant bit of the command byte first.
  function automatic logic [6:0] frame_crc7(input logic [7:0] head, input logic [31:0] arg);
    logic [39:0] frame;
    logic [6:0]  crc;
    logic        feedback;
    frame = {head, arg};
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      feedback = crc[6] ^ frame[i];
      crc = {crc[5:0], 1'b0};
      if (feedback) begin
        crc = crc ^ sdspi_pkg::CRC7_GEN[6:0];
      end
    end
    return crc;
  endfunction

  // Advances the predicted sequencer by one accepted item. Returns 1 and the
  // reply when the item causes one, 0 when the unit drops it.
  function automatic bit predict_reply(input sdspi_pkg::sdspi_item_t it,
                                       output sdspi_pkg::sdspi_res_t rep);
    logic [7:0] head;
    rep = '0;
    if (it.opcode == sdspi_pkg::OP_START) begin
      if (seq_phase != SEQ_IDLE) begin
        return 1'b0;
      end
      if (it.cmd_index >= sdspi_pkg::CMD_LIMIT) begin
        rep.done_res = 1'b1;
        rep.status = sdspi_pkg::ST_BAD_CMD;
        return 1'b1;
      end
      head = sdspi_pkg::START_TOKEN | it.cmd_index;
      arg_latch = it.argument;
      frame_crc = frame_crc7(head, it.argument);
      resp_goal = (it.resp_len == 4'd0) ? 4'd1 : it.resp_len;
      resp_seen = '0;
      polls_made = '0;
      frame_pos = '0;
      end_status = sdspi_pkg::ST_OK;
      seq_phase = SEQ_FRAME;
      rep.send_valid = 1'b1;
      rep.send_byte = head;
      return 1'b1;
    end

    case (seq_phase)
      SEQ_IDLE: begin
        return 1'b0;
      end
      // The trailing byte closes the exchange whatever came back on the bus.
      SEQ_TRAIL: begin
        seq_phase = SEQ_IDLE;
        rep.done_res = 1'b1;
        rep.status = end_status;
        return 1'b1;
      end
      default: begin
      end
    endcase

    if (it.bus_error) begin
      seq_phase = SEQ_IDLE;
      rep.done_res = 1'b1;
      rep.status = sdspi_pkg::ST_COM_ERR;
      return 1'b1;
    end

    rep.send_valid = 1'b1;
    rep.send_byte = sdspi_pkg::FILL_BYTE;
    case (seq_phase)
      SEQ_FRAME: begin
        if (frame_pos >= sdspi_pkg::FRAME_BYTES) begin
          seq_phase = SEQ_POLL;
          polls_made = '0;
        end else begin
          frame_pos = frame_pos + 3'd1;
          if (frame_pos < sdspi_pkg::FRAME_BYTES) begin
            rep.send_byte = arg_latch[8 * (sdspi_pkg::FRAME_LAST - frame_pos) +: 8];
          end else begin
            rep.send_byte = {frame_crc, 1'b1};
          end
        end
      end
      SEQ_POLL: begin
        polls_made = polls_made + 1'b1;
        if (!it.rx_byte[7]) begin
          resp_seen = 4'd1;
          rep.resp_valid = 1'b1;
          rep.resp_byte = it.rx_byte;
          if ((it.rx_byte & sdspi_pkg::R1_ERR_MASK) != 8'd0) begin
            end_status = sdspi_pkg::ST_R1_ERR;
            seq_phase = SEQ_TRAIL;
          end else if (resp_goal > 4'd1) begin
            seq_phase = SEQ_DATA;
          end else begin
            end_status = sdspi_pkg::ST_OK;
            seq_phase = SEQ_TRAIL;
          end
        end else if (polls_made >= poll_limit_now) begin
          seq_phase = SEQ_IDLE;
          rep = '0;
          rep.done_res = 1'b1;
          rep.status = sdspi_pkg::ST_TIMEOUT;
        end
      end
      default: begin
        resp_seen = resp_seen + 4'd1;
        if (resp_seen >= resp_goal) begin
          end_status = sdspi_pkg::ST_OK;
          seq_phase = SEQ_TRAIL;
        end
        rep.resp_valid = 1'b1;
        rep.resp_byte = it.rx_byte;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic sdspi_pkg::sdspi_item_t mk_item(input logic op, input logic [7:0] cmd,
                                                     input logic [31:0] arg,
                                                     input logic [3:0] len,
                                                     input logic [7:0] rx, input logic err);
    return sdspi_pkg::sdspi_item_t'({op, cmd, arg, len, rx, err});
  endfunction

  function automatic sdspi_pkg::sdspi_res_t mk_reply(input logic sv, input logic [7:0] sb,
                                                     input logic rv, input logic [7:0] rb,
                                                     input logic dn, input logic [2:0] st);
    return sdspi_pkg::sdspi_res_t'({sv, sb, rv, rb, dn, st});
  endfunction

  task automatic add_row(input sdspi_pkg::sdspi_item_t it, input bit typed,
                         input sdspi_pkg::sdspi_res_t rep);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.item = it;
    row.limit = '0;
    row.typed = typed;
    row.reply = rep;
    stim_table.push_back(row);
  endtask

  task automatic add_cfg(input logic [sdspi_pkg::POLL_W-1:0] limit);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.item = '0;
    row.limit = limit;
    row.typed = 1'b0;
    row.reply = '0;
    stim_table.push_back(row);
  endtask

  // Directed part. Replies are typed in only where they are obvious: command
  // rejection, the opening frame byte, bus errors, timeout and R1 error. All
  // other rows are checked against the prediction.
  task automatic build_directed_table();
    sdspi_pkg::sdspi_res_t bad_cmd;
    bad_cmd = mk_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, sdspi_pkg::ST_BAD_CMD);
    // Command indexes at and above the limit are rejected from idle.
    add_row(mk_item(sdspi_pkg::OP_START, 8'hFF, 32'hFFFF_FFFF, 4'hF, 8'hFF, 1'b1),
            1'b1, bad_cmd);
    add_row(mk_item(sdspi_pkg::OP_START, sdspi_pkg::CMD_LIMIT, 32'h0, 4'd1, 8'h00, 1'b0),
            1'b1, bad_cmd);
    // A completed exchange with no transaction running is dropped.
    add_row(mk_item(sdspi_pkg::OP_XFER, 8'h00, 32'h0, 4'd0, 8'hFF, 1'b1), 1'b0, '0);
    // Lowest command, zero argument, response length of zero.
    add_row(mk_item(sdspi_pkg::OP_START, 8'h00, 32'h0, 4'd0, 8'h00, 1'b0), 1'b1,
            mk_reply(1'b1, sdspi_pkg::START_TOKEN, 1'b0, 8'h00, 1'b0, sdspi_pkg::ST_OK));
    // A second start while busy is dropped.
    add_row(mk_item(sdspi_pkg::OP_START, 8'd63, 32'hFFFF_FFFF, 4'd8, 8'h7F, 1'b1),
            1'b0, '0);
    // Bus error on the first frame byte.
    add_row(mk_item(sdspi_pkg::OP_XFER, 8'h00, 32'h0, 4'd0, 8'h00, 1'b1), 1'b1,
            mk_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, sdspi_pkg::ST_COM_ERR));
    // A poll limit of zero gives up after the very first poll.
    add_cfg('0);
    add_row(mk_item(sdspi_pkg::OP_START, 8'd63, 32'hFFFF_FFFF, 4'hF, 8'h00, 1'b0), 1'b1,
            mk_reply(1'b1, sdspi_pkg::START_TOKEN | 8'd63, 1'b0, 8'h00, 1'b0,
                     sdspi_pkg::ST_OK));
    repeat (6) add_row(mk_item(sdspi_pkg::OP_XFER, 8'h00, 32'h0, 4'd0, 8'hFF, 1'b0),
                       1'b0, '0);
    add_row(mk_item(sdspi_pkg::OP_XFER, 8'h00, 32'h0, 4'd0, 8'hFF, 1'b0), 1'b1,
            mk_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, sdspi_pkg::ST_TIMEOUT));
    // Back to the reset limit; an R1 byte with every error flag set, then
    // a bus error on the trailing byte, which must not change the status.
    add_cfg(sdspi_pkg::POLL_LIMIT_RST);
    add_row(mk_item(sdspi_pkg::OP_START, 8'd17, 32'h1234_5678, 4'd2, 8'h00, 1'b0),
            1'b0, '0);
    repeat (6) add_row(mk_item(sdspi_pkg::OP_XFER, 8'h00, 32'h0, 4'd0, 8'hA5, 1'b0),
                       1'b0, '0);
    add_row(mk_item(sdspi_pkg::OP_XFER, 8'h00, 32'h0, 4'd0, 8'h7C, 1'b0), 1'b0, '0);
    add_row(mk_item(sdspi_pkg::OP_XFER, 8'h00, 32'h0, 4'd0, 8'h00, 1'b1), 1'b1,
            mk_reply(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, sdspi_pkg::ST_R1_ERR));
  endtask

  // Builds the next random item from where the predicted sequencer stands, so
  // that most items walk a full exchange. The rest are stray completions,
  // starts while busy, rejected commands and bus errors.
  function automatic sdspi_pkg::sdspi_item_t next_stimulus();
    sdspi_pkg::sdspi_item_t it;
    int unsigned lim;
    lim = (poll_limit_now == '0) ? 1 : poll_limit_now;
    it = mk_item(sdspi_pkg::OP_XFER, 8'($urandom_range(255)), $urandom,
                 4'($urandom_range(15)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    if (seq_phase == SEQ_IDLE) begin
      if ($urandom_range(99) < 12) begin
        return it;
      end
      it.opcode = sdspi_pkg::OP_START;
      if ($urandom_range(99) < 88) begin
        it.cmd_index = 8'($urandom_range(63));
      end
      if ($urandom_range(99) < 80) begin
        it.resp_len = 4'($urandom_range(8, 1));
      end
      // Busy polls before the R1 byte: sometimes exactly at the limit or one
      // past it, so both the last allowed poll and the timeout are reached.
      if (lim <= 16 && $urandom_range(99) < 40) begin
        polls_to_wait = lim - 1 + $urandom_range(1);
      end else begin
        polls_to_wait = $urandom_range(3);
      end
      return it;
    end
    if ($urandom_range(99) < 4) begin
      it.opcode = sdspi_pkg::OP_START;
      return it;
    end
    if (seq_phase != SEQ_TRAIL) begin
      it.bus_error = ($urandom_range(99) < 2);
    end
    if (seq_phase == SEQ_POLL) begin
      if (polls_to_wait != 0) begin
        it.rx_byte[7] = 1'b1;
        polls_to_wait--;
      end else begin
        it.rx_byte[7] = 1'b0;
        if ($urandom_range(99) < 75) begin
          it.rx_byte[6:2] = '0;
        end
      end
    end
    return it;
  endfunction

  // Presents one item, with random idle cycles ahead of it, and records the
  // reply it should cause once the unit has taken it.
  task automatic send_item(input sdspi_pkg::sdspi_item_t it, input bit typed,
                           input sdspi_pkg::sdspi_res_t typed_rep, output bit produced);
    sdspi_pkg::sdspi_res_t rep;
    while (!quiet && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.opcode;
    in_tdata <= {3'b000, it.bus_error, it.rx_byte, it.resp_len, it.argument, it.cmd_index};
    do @(posedge clk); while (!in_tready);
    produced = predict_reply(it, rep);
    if (typed) begin
      rep = typed_rep;
    end
    if (produced || typed) begin
      pending_replies.push_back(rep);
    end
  endtask

  // Holds the input side off until every predicted reply has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // The poll limit is only written with the unit idle and fully drained.
  task automatic write_poll_limit(input logic [sdspi_pkg::POLL_W-1:0] limit);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    poll_limit_now = limit;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Reply checker and result-side back-pressure. Values are read right after
  // the edge, before any register in the unit has moved.
  always @(posedge clk) begin : reply_monitor
    sdspi_pkg::sdspi_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: expected no reply, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("send_valid", 8'(want.send_valid), 8'(out_tdata[0]));
        check_field("send_byte", want.send_byte, out_tdata[8:1]);
        check_field("resp_valid", 8'(want.resp_valid), 8'(out_tdata[9]));
        check_field("resp_byte", want.resp_byte, out_tdata[17:10]);
        check_field("done_res", 8'(want.done_res), 8'(out_tdata[18]));
        check_field("status", 8'(want.status), 8'(out_tdata[21:19]));
      end
    end
    out_tready <= quiet || ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [sdspi_pkg::POLL_W-1:0] phase_limits [NUM_PHASES];
    bit                           produced;
    int unsigned                  replies_seen;
    // Small limits come first, then zero and the reset limit; the quiet phase runs with a
    // small limit so timeouts also happen at full rate.
    phase_limits[0] = 17'd1;
    phase_limits[1] = 17'd4;
    phase_limits[2] = '0;
    phase_limits[3] = sdspi_pkg::POLL_LIMIT_RST;
    phase_limits[4] = 17'd2;
    phase_limits[5] = 17'($urandom_range(16, 3));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    build_directed_table();
    foreach (stim_table[r]) begin
      if (stim_table[r].kind == ROW_CFG) begin
        write_poll_limit(stim_table[r].limit);
      end else begin
        send_item(stim_table[r].item, stim_table[r].typed, stim_table[r].reply, produced);
      end
    end

    // Random phases, each ending on an idle sequencer so the next limit can
    // be written safely. Now and then the sender also stops mid-transaction
    // until the result side has caught up.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_poll_limit(phase_limits[p]);
      quiet = (p == 1);
      replies_seen = 0;
      while (replies_seen < PHASE_ITEMS || seq_phase != SEQ_IDLE) begin
        if ($urandom_range(199) == 0) begin
          wait_drained();
        end
        send_item(next_stimulus(), 1'b0, '0, produced);
        if (produced) begin
          replies_seen++;
        end
      end
    end
    quiet = 1'b0;

    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
